### hw/rtl/lsh_pkg.sv
// shared types, constants and helpers of the laplacian sharpen core
`default_nettype none

package lsh_pkg;

   localparam int MAX_WIDTH        = 4096;
   localparam int MAX_HEIGHT       = 4096;
   localparam int COL_BITS         = $clog2(MAX_WIDTH);
   localparam int ROW_BITS         = $clog2(MAX_HEIGHT);
   localparam int HELD_BITS        = $clog2(MAX_WIDTH + 2);
   localparam int DIM_BITS         = 13;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CHAN_BITS        = 8;
   localparam int COLOR_CHANNELS   = 3;
   localparam int PIXEL_BITS       = 4 * CHAN_BITS;
   localparam int KERNEL_BITS      = CHAN_BITS + 5;
   localparam int WIN_SIZE         = 3;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_DEPTH      = 2 ** QUEUE_PTR_BITS;
   localparam int QUEUE_COUNT_BITS = QUEUE_PTR_BITS + 1;

   localparam int CHAN_MAX         = 255;
   localparam int WIDTH_RESET      = 640;
   localparam int HEIGHT_RESET     = 480;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = CSR_INDEX_BITS'(2);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // where the emitted pixel comes from
   typedef enum logic [2:0] {
      SRC_TAIL,
      SRC_CENTER,
      SRC_SHARP,
      SRC_PREV,
      SRC_OLDER
   } src_type;

   typedef struct packed {
      logic                 kind;
      logic [CHAN_BITS-1:0] red_in;
      logic [CHAN_BITS-1:0] green_in;
      logic [CHAN_BITS-1:0] blue_in;
      logic [CHAN_BITS-1:0] alpha_in;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red_out;
      logic [CHAN_BITS-1:0] green_out;
      logic [CHAN_BITS-1:0] blue_out;
      logic [CHAN_BITS-1:0] alpha_out;
      logic                 frame_end;
   } rsp_word_type;

   // classified word handed from front to back
   typedef struct packed {
      logic                  is_pixel;
      logic                  emit;
      src_type               src;
      logic                  last_col;
      logic                  frame_end;
      logic [COL_BITS-1:0]   addr;
      logic [PIXEL_BITS-1:0] pixel;
   } job_word_type;

   function automatic int dim_minus_one(logic [DIM_BITS-1:0] value, int max_dim);
      int v;
      v = int'(value);
      if (v < 1) begin
         return 0;
      end
      if (v > max_dim) begin
         return max_dim - 1;
      end
      return v - 1;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/lsh_ram.sv
// generic single write, single registered read ram
`default_nettype none

module lsh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/lsh_front.sv
// front end: control registers, stream position counters and word classification
`default_nettype none

module lsh_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  lsh_pkg::req_word_type                req_word,
   input  logic                                 csr_we,
   input  logic [lsh_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lsh_pkg::DIM_BITS-1:0]         csr_wdata,
   output logic                                 job_valid,
   input  logic                                 job_ready,
   output lsh_pkg::job_word_type                job_word,
   output logic                                 mode
);

   import lsh_pkg::*;

   logic                 mode_ff, mode_in;
   logic [COL_BITS-1:0]  wm1_ff, wm1_in;
   logic [ROW_BITS-1:0]  hm1_ff, hm1_in;
   logic [COL_BITS-1:0]  icol_ff, icol_in;
   logic [COL_BITS-1:0]  ocol_ff, ocol_in;
   logic [ROW_BITS-1:0]  orow_ff, orow_in;
   logic [HELD_BITS-1:0] held_ff, held_in;

   logic accept;
   logic is_pixel;
   logic held_full;
   logic border;
   logic emit;
   logic restart;

   always_comb begin
      is_pixel  = req_word.kind == KIND_PIXEL;
      held_full = held_ff >= (HELD_BITS'(wm1_ff) + HELD_BITS'(2));
      border    = (wm1_ff < COL_BITS'(2)) || (hm1_ff < ROW_BITS'(2))
                  || (orow_ff == '0) || (orow_ff == hm1_ff)
                  || (ocol_ff == '0) || (ocol_ff == wm1_ff);
      emit      = is_pixel ? held_full : ((held_ff != '0) && border);
      req_ready = job_ready;
      accept    = req_valid && job_ready;
      job_valid = req_valid && (is_pixel || emit);
      restart   = csr_we && ((csr_index == CSR_WIDTH) || (csr_index == CSR_HEIGHT));

      job_word.is_pixel  = is_pixel;
      job_word.emit      = emit;
      job_word.last_col  = icol_ff == wm1_ff;
      job_word.frame_end = (orow_ff == hm1_ff) && (ocol_ff == wm1_ff);
      job_word.addr      = is_pixel ? icol_ff : ocol_ff;
      job_word.pixel     = {req_word.alpha_in, req_word.blue_in,
                            req_word.green_in, req_word.red_in};
      priority if (!is_pixel) begin
         job_word.src = held_full ? SRC_OLDER : SRC_PREV;
      end else if (icol_ff == '0) begin
         job_word.src = SRC_TAIL;
      end else if (border) begin
         job_word.src = SRC_CENTER;
      end else begin
         job_word.src = SRC_SHARP;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      wm1_in  = wm1_ff;
      hm1_in  = hm1_ff;
      icol_in = icol_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      held_in = held_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:   mode_in = csr_wdata[0];
            CSR_WIDTH:  wm1_in  = COL_BITS'(dim_minus_one(csr_wdata, MAX_WIDTH));
            CSR_HEIGHT: hm1_in  = ROW_BITS'(dim_minus_one(csr_wdata, MAX_HEIGHT));
            default: ;
         endcase
      end
      if (restart) begin
         icol_in = '0;
         ocol_in = '0;
         orow_in = '0;
         held_in = '0;
      end else if (accept) begin
         if (is_pixel) begin
            icol_in = (icol_ff == wm1_ff) ? '0 : icol_ff + COL_BITS'(1);
            if (!held_full) begin
               held_in = held_ff + HELD_BITS'(1);
            end
         end else if (emit) begin
            held_in = held_ff - HELD_BITS'(1);
         end
         if (emit) begin
            if (ocol_ff == wm1_ff) begin
               ocol_in = '0;
               orow_in = (orow_ff == hm1_ff) ? '0 : orow_ff + ROW_BITS'(1);
            end else begin
               ocol_in = ocol_ff + COL_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         wm1_ff  <= COL_BITS'(WIDTH_RESET - 1);
         hm1_ff  <= ROW_BITS'(HEIGHT_RESET - 1);
         icol_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         held_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         wm1_ff  <= wm1_in;
         hm1_ff  <= hm1_in;
         icol_ff <= icol_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
         held_ff <= held_in;
      end
   end

   assign mode = mode_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_BITS'(wm1_ff) + HELD_BITS'(2))
      else $error("held pixel count beyond one line plus one");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (icol_ff <= wm1_ff) && (ocol_ff <= wm1_ff) && (orow_ff <= hm1_ff))
      else $error("stream position outside the frame");

endmodule

`default_nettype wire

### hw/rtl/lsh_queue.sv
// short queue of classified words between front and back
`default_nettype none

module lsh_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  lsh_pkg::job_word_type push_word,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output lsh_pkg::job_word_type pop_word
);

   import lsh_pkg::*;

   job_word_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic                        push;
   logic                        pop;

   always_comb begin
      push_ready = count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH);
      pop_valid  = count_ff != '0;
      pop_word   = entry_ff[rd_ptr_ff];
      push       = push_valid && push_ready;
      pop        = pop_valid && pop_ready;
      wr_ptr_in  = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

### hw/rtl/lsh_back.sv
// back end: line stores, 3x3 window, kernel arithmetic and output register
`default_nettype none

module lsh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mode,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  lsh_pkg::job_word_type job_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lsh_pkg::rsp_word_type rsp_word
);

   import lsh_pkg::*;

   typedef struct packed {
      src_type               src;
      logic                  frame_end;
      logic [PIXEL_BITS-1:0] alt;
   } stage_word_type;

   logic out_load;
   logic s2_free;
   logic s1_move;
   logic s1_free;
   logic issue;
   logic s1_write;
   logic fwd;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic lw_valid_ff, lw_valid_in;

   job_word_type          s1_ff;
   stage_word_type        s2_ff, s2_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic [COL_BITS-1:0]   lw_addr_ff;
   logic [PIXEL_BITS-1:0] lw_prev_ff;
   logic [PIXEL_BITS-1:0] lw_older_ff;
   logic [PIXEL_BITS-1:0] tail_ff;
   logic [PIXEL_BITS-1:0] win_ff [WIN_SIZE][WIN_SIZE];

   logic [PIXEL_BITS-1:0] prev_rd;
   logic [PIXEL_BITS-1:0] older_rd;
   logic [PIXEL_BITS-1:0] mid;
   logic [PIXEL_BITS-1:0] top;
   logic [PIXEL_BITS-1:0] sharp_px;
   logic [PIXEL_BITS-1:0] result_px;

   function automatic logic [CHAN_BITS-1:0] sharpen_chan(
      logic                 eight,
      logic [CHAN_BITS-1:0] c,
      logic [CHAN_BITS-1:0] e0,
      logic [CHAN_BITS-1:0] e1,
      logic [CHAN_BITS-1:0] e2,
      logic [CHAN_BITS-1:0] e3,
      logic [CHAN_BITS-1:0] d0,
      logic [CHAN_BITS-1:0] d1,
      logic [CHAN_BITS-1:0] d2,
      logic [CHAN_BITS-1:0] d3
   );
      logic [KERNEL_BITS-1:0] cw;
      logic [KERNEL_BITS-1:0] ew;
      logic [KERNEL_BITS-1:0] dw;
      logic [KERNEL_BITS-1:0] v;
      cw = KERNEL_BITS'(c);
      ew = KERNEL_BITS'(e0) + KERNEL_BITS'(e1) + KERNEL_BITS'(e2) + KERNEL_BITS'(e3);
      dw = KERNEL_BITS'(d0) + KERNEL_BITS'(d1) + KERNEL_BITS'(d2) + KERNEL_BITS'(d3);
      if (eight) begin
         v = (cw << 3) + cw - ew - dw;
      end else begin
         v = (cw << 2) + cw - ew;
      end
      if (v[KERNEL_BITS-1]) begin
         return '0;
      end
      if (v > KERNEL_BITS'(CHAN_MAX)) begin
         return CHAN_BITS'(CHAN_MAX);
      end
      return v[CHAN_BITS-1:0];
   endfunction

   lsh_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_prev_store (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_ff.addr),
      .wr_data (s1_ff.pixel),
      .rd_en   (issue),
      .rd_addr (job_word.addr),
      .rd_data (prev_rd)
   );

   lsh_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_older_store (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_ff.addr),
      .wr_data (mid),
      .rd_en   (issue),
      .rd_addr (job_word.addr),
      .rd_data (older_rd)
   );

   // stage handshake
   always_comb begin
      out_load  = !rsp_valid_ff || rsp_ready;
      s2_free   = !s2_valid_ff || out_load;
      s1_move   = s1_valid_ff && s2_free;
      s1_free   = !s1_valid_ff || s2_free;
      issue     = job_valid && s1_free;
      job_ready = s1_free;
      s1_write  = s1_move && s1_ff.is_pixel;

      s1_valid_in  = s1_free ? job_valid : s1_valid_ff;
      s2_valid_in  = s2_free ? (s1_move && s1_ff.emit) : s2_valid_ff;
      rsp_valid_in = out_load ? s2_valid_ff : rsp_valid_ff;
      lw_valid_in  = lw_valid_ff || s1_write;
   end

   // read data with bypass of the write that went in alongside the read
   always_comb begin
      fwd = lw_valid_ff && (lw_addr_ff == s1_ff.addr);
      mid = fwd ? lw_prev_ff : prev_rd;
      top = fwd ? lw_older_ff : older_rd;

      s2_in.src       = s1_ff.src;
      s2_in.frame_end = s1_ff.frame_end;
      unique case (s1_ff.src)
         SRC_TAIL:                         s2_in.alt = tail_ff;
         SRC_PREV:                         s2_in.alt = mid;
         SRC_OLDER:                        s2_in.alt = top;
         SRC_CENTER, SRC_SHARP:            s2_in.alt = '0;
         default:                          s2_in.alt = '0;
      endcase
   end

   always_comb begin
      sharp_px[PIXEL_BITS-1 -: CHAN_BITS] = win_ff[1][1][PIXEL_BITS-1 -: CHAN_BITS];
      for (int k = 0; k < COLOR_CHANNELS; k++) begin
         sharp_px[CHAN_BITS*k +: CHAN_BITS] = sharpen_chan(mode,
            win_ff[1][1][CHAN_BITS*k +: CHAN_BITS],
            win_ff[0][1][CHAN_BITS*k +: CHAN_BITS],
            win_ff[1][0][CHAN_BITS*k +: CHAN_BITS],
            win_ff[1][2][CHAN_BITS*k +: CHAN_BITS],
            win_ff[2][1][CHAN_BITS*k +: CHAN_BITS],
            win_ff[0][0][CHAN_BITS*k +: CHAN_BITS],
            win_ff[0][2][CHAN_BITS*k +: CHAN_BITS],
            win_ff[2][0][CHAN_BITS*k +: CHAN_BITS],
            win_ff[2][2][CHAN_BITS*k +: CHAN_BITS]);
      end

      unique case (s2_ff.src)
         SRC_SHARP:                     result_px = sharp_px;
         SRC_CENTER:                    result_px = win_ff[1][1];
         SRC_TAIL, SRC_PREV, SRC_OLDER: result_px = s2_ff.alt;
         default:                       result_px = s2_ff.alt;
      endcase

      rsp_word_in.red_out   = result_px[CHAN_BITS*0 +: CHAN_BITS];
      rsp_word_in.green_out = result_px[CHAN_BITS*1 +: CHAN_BITS];
      rsp_word_in.blue_out  = result_px[CHAN_BITS*2 +: CHAN_BITS];
      rsp_word_in.alpha_out = result_px[CHAN_BITS*3 +: CHAN_BITS];
      rsp_word_in.frame_end = s2_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lw_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         lw_valid_ff  <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff <= job_word;
      end
      if (s1_write) begin
         lw_addr_ff  <= s1_ff.addr;
         lw_prev_ff  <= s1_ff.pixel;
         lw_older_ff <= mid;
         for (int r = 0; r < WIN_SIZE; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= top;
         win_ff[1][2] <= mid;
         win_ff[2][2] <= s1_ff.pixel;
         if (s1_ff.last_col) begin
            tail_ff <= mid;
         end
      end
      if (s1_move) begin
         s2_ff <= s2_in;
      end
      if (out_load && s2_valid_ff) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_load) |-> !s1_move)
      else $error("window shifted under a stalled result");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result word without a computed pixel");

endmodule

`default_nettype wire

### hw/rtl/laplacian_sharpen_3x3_core.sv
// top level of the 3x3 laplacian sharpen core for an rgba pixel stream
// throughput: one word per cycle on req and on rsp while rsp_ready holds, set by one pass per word through each stage
// a word that yields a result passes the queue, stage 1, stage 2 and the output register on its way to rsp;
// the pixel it carries is the one taken image_width + 1 pixel words earlier
// reset: synchronous, clears queue, position counters and stage control, mode 0, 640 x 480; line stores keep contents
`default_nettype none

module laplacian_sharpen_3x3_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lsh_pkg::req_word_type              req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lsh_pkg::rsp_word_type              rsp_word,
   input  logic                               csr_we,
   input  logic [lsh_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lsh_pkg::DIM_BITS-1:0]       csr_wdata
);

   import lsh_pkg::*;

   logic         push_valid;
   logic         push_ready;
   job_word_type push_word;
   logic         pop_valid;
   logic         pop_ready;
   job_word_type pop_word;
   logic         mode;

   lsh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_word  (push_word),
      .mode      (mode)
   );

   lsh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   lsh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_word  (pop_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
